// ===== sv/tmb_pkg.sv =====
// Shared constants and types for the model matrix builder.
// No dependencies.
package tmb_pkg;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ANGLE_BITS_DEF = 16;
	localparam logic [31:0] POLY_A  = 32'd1686629713;
	localparam logic [31:0] POLY_B  = 32'd688904866;
	localparam logic [31:0] POLY_C  = 32'd76016977;
	localparam logic [31:0] ONE_Q30 = 32'd1073741824;

	// Q1.15 sine/cosine pair
	typedef struct packed {
		logic signed [15:0] sn;
		logic signed [15:0] cs;
	} sc_t;
endpackage

// ===== sv/tmb_sincos.sv =====
// Pipelined quarter-wave polynomial sine/cosine, six register stages.
// Depends on tmb_pkg.
module tmb_sincos #(
	parameter int ANGLE_BITS = tmb_pkg::ANGLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [15:0]  angle,
	output tmb_pkg::sc_t        res
);
	localparam int FB = ANGLE_BITS - 2;

	logic [ANGLE_BITS-1:0] u;
	logic [1:0]            quad;
	logic [FB-1:0]         f;
	logic [31:0]           z0;
	logic [31:0]           w0;

	// angle sign-extended to 32 then reduced
	assign u    = ANGLE_BITS'($unsigned({{16{angle[15]}}, angle}));
	assign quad = u[ANGLE_BITS-1 -: 2];
	assign f    = u[FB-1:0];
	assign z0   = 32'(({32'd0, f} << (32 - ANGLE_BITS)));
	assign w0   = tmb_pkg::ONE_Q30 - z0;

	// lane 0: sine operand, lane 1: cosine operand (next quadrant)
	logic [31:0] za_s1, zb_s1;
	logic [1:0]  q_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			za_s1 <= quad[0] ? w0 : z0;
			zb_s1 <= quad[0] ? z0 : w0;
			q_s1  <= quad;
		end
	end

	logic [31:0] za_s2, zb_s2, z2a_s2, z2b_s2;
	logic [1:0]  q_s2;
	logic [63:0] pa1, pb1;
	assign pa1 = za_s1 * za_s1;
	assign pb1 = zb_s1 * zb_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			za_s2 <= za_s1; zb_s2 <= zb_s1; q_s2 <= q_s1;
			z2a_s2 <= pa1[61:30];
			z2b_s2 <= pb1[61:30];
		end
	end

	logic [31:0] za_s3, zb_s3, z2a_s3, z2b_s3, ta_s3, tb_s3;
	logic [1:0]  q_s3;
	logic [63:0] pa2, pb2;
	assign pa2 = z2a_s2 * tmb_pkg::POLY_C;
	assign pb2 = z2b_s2 * tmb_pkg::POLY_C;
	always_ff @(posedge clk) begin
		if (en) begin
			za_s3 <= za_s2; zb_s3 <= zb_s2; q_s3 <= q_s2;
			z2a_s3 <= z2a_s2; z2b_s3 <= z2b_s2;
			ta_s3 <= tmb_pkg::POLY_B - pa2[61:30];
			tb_s3 <= tmb_pkg::POLY_B - pb2[61:30];
		end
	end

	logic [31:0] za_s4, zb_s4, ta_s4, tb_s4;
	logic [1:0]  q_s4;
	logic [63:0] pa3, pb3;
	assign pa3 = z2a_s3 * ta_s3;
	assign pb3 = z2b_s3 * tb_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			za_s4 <= za_s3; zb_s4 <= zb_s3; q_s4 <= q_s3;
			ta_s4 <= tmb_pkg::POLY_A - pa3[61:30];
			tb_s4 <= tmb_pkg::POLY_A - pb3[61:30];
		end
	end

	logic [31:0] sa_s5, sb_s5;
	logic [1:0]  q_s5;
	logic [63:0] pa4, pb4;
	assign pa4 = za_s4 * ta_s4;
	assign pb4 = zb_s4 * tb_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			q_s5  <= q_s4;
			sa_s5 <= pa4[61:30];
			sb_s5 <= pb4[61:30];
		end
	end

	logic [31:0] ra, rb;
	logic [15:0] ma, mb;
	logic [1:0]  qc;
	assign ra = (sa_s5 + 32'd16384) >> 15;
	assign rb = (sb_s5 + 32'd16384) >> 15;
	assign ma = (ra > 32'd32767) ? 16'd32767 : ra[15:0];
	assign mb = (rb > 32'd32767) ? 16'd32767 : rb[15:0];
	assign qc = q_s5 + 2'd1;
	always_ff @(posedge clk) begin
		if (en) begin
			res.sn <= q_s5[1] ? -ma : ma;
			res.cs <= qc[1] ? -mb : mb;
		end
	end
endmodule

// ===== sv/tmb_matrix.sv =====
// Rotation entry products, Q30 rounding and scaling for one matrix entry.
// Depends on tmb_pkg.
module tmb_entry (
	input  logic                clk,
	input  logic                en,
	input  logic signed [15:0]  a,     // pair 1 operands (times 2^15)
	input  logic signed [15:0]  b,
	input  logic signed [15:0]  c,     // triple term c*d*e
	input  logic signed [15:0]  d,
	input  logic signed [15:0]  e,
	input  logic                neg1,
	input  logic                neg2,
	input  logic                use2,
	input  logic signed [31:0]  scale,
	output logic signed [31:0]  m
);
	// stage 1: two 16x16 products
	logic signed [31:0] p1_s1, p2_s1;
	logic signed [15:0] e_s1;
	logic signed [31:0] sc_s1;
	logic               n1_s1, n2_s1, u2_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= a * b; p2_s1 <= c * d; e_s1 <= e;
			sc_s1 <= scale; n1_s1 <= neg1; n2_s1 <= neg2; u2_s1 <= use2;
		end
	end

	// stage 2: Q45 sum
	logic signed [47:0] t1, t2;
	logic signed [47:0] q45_s2;
	logic signed [31:0] sc_s2;
	assign t1 = {{16{p1_s1[31]}}, p1_s1} <<< 15;
	assign t2 = u2_s1 ? 48'(p2_s1) * 48'(e_s1) : 48'sd0;
	always_ff @(posedge clk) begin
		if (en) begin
			q45_s2 <= (n1_s1 ? -t1 : t1) + (n2_s1 ? -t2 : t2);
			sc_s2  <= sc_s1;
		end
	end

	// stage 3: round to Q30; stage 4: multiply by scale (33x32 signed)
	logic signed [47:0] rq;
	logic signed [32:0] q30;
	logic signed [31:0] sc_s3;
	logic signed [32:0] q30_s3;
	assign rq  = (q45_s2 + 48'sd16384) >>> 15;
	assign q30 = rq[32:0];
	always_ff @(posedge clk) begin
		if (en) begin
			q30_s3 <= q30;
			sc_s3  <= sc_s2;
		end
	end

	logic signed [64:0] prod_s4;
	always_ff @(posedge clk) begin
		if (en) prod_s4 <= q30_s3 * sc_s3;
	end

	// stage 5: round by 30 bits, saturate
	logic signed [64:0] rv;
	logic signed [34:0] v;
	assign rv = (prod_s4 + (65'sd1 <<< 29)) >>> 30;
	assign v  = rv[34:0];
	always_ff @(posedge clk) begin
		if (en) begin
			if (v > 35'sh07FFFFFFF)      m <= 32'sh7FFFFFFF;
			else if (v < -35'sh080000000) m <= 32'sh80000000;
			else                          m <= v[31:0];
		end
	end
endmodule

// ===== sv/trs_model_matrix_builder.sv =====
// Top level: model matrix T*Rx*Ry*Rz*S builder, fully pipelined.
// Depends on tmb_pkg, tmb_sincos, tmb_entry.
//
//  channel | signals                                         | direction
//  in      | in_valid, in_ready, pos_*, angle_*, scale_*     | to block
//  out     | out_valid, out_ready, m00..m23                  | from block
//
// One beat per cycle unless the output stalls; 6 sin/cos stages, then 5 entry stages.
// The whole pipe advances when the output register is empty or being drained.
// arst_n clears valid bits only; data registers carry no reset.
// A stall freezes every stage in place, so nothing is lost or repeated.
module trs_model_matrix_builder #(
	parameter int ANGLE_BITS = tmb_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x, pos_y, pos_z,
	input  logic signed [15:0] angle_x, angle_y, angle_z,
	input  logic signed [31:0] scale_x, scale_y, scale_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] m00, m01, m02, m03,
	output logic signed [31:0] m10, m11, m12, m13,
	output logic signed [31:0] m20, m21, m22, m23
);
	localparam int LAT = 10;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[LAT-2:0], in_valid};
			out_valid <= vld_q[LAT-1];
		end
	end

	tmb_pkg::sc_t rx, ry, rz;
	tmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_scx (.clk, .en, .angle(angle_x), .res(rx));
	tmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_scy (.clk, .en, .angle(angle_y), .res(ry));
	tmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_scz (.clk, .en, .angle(angle_z), .res(rz));

	// delay line for position and scale matching the sin/cos latency
	localparam int SD = 6;
	logic signed [31:0] px_q [SD], py_q [SD], pz_q [SD];
	logic signed [31:0] sx_q [SD], sy_q [SD], sz_q [SD];
	always_ff @(posedge clk) begin
		if (en) begin
			px_q[0] <= pos_x; py_q[0] <= pos_y; pz_q[0] <= pos_z;
			sx_q[0] <= scale_x; sy_q[0] <= scale_y; sz_q[0] <= scale_z;
			for (int i = 1; i < SD; i++) begin
				px_q[i] <= px_q[i-1]; py_q[i] <= py_q[i-1]; pz_q[i] <= pz_q[i-1];
				sx_q[i] <= sx_q[i-1]; sy_q[i] <= sy_q[i-1]; sz_q[i] <= sz_q[i-1];
			end
		end
	end

	localparam int PD = 5;
	logic signed [31:0] tx_q [PD], ty_q [PD], tz_q [PD];
	always_ff @(posedge clk) begin
		if (en) begin
			tx_q[0] <= px_q[SD-1]; ty_q[0] <= py_q[SD-1]; tz_q[0] <= pz_q[SD-1];
			for (int i = 1; i < PD; i++) begin
				tx_q[i] <= tx_q[i-1]; ty_q[i] <= ty_q[i-1]; tz_q[i] <= tz_q[i-1];
			end
		end
	end
	assign m03 = tx_q[PD-1];
	assign m13 = ty_q[PD-1];
	assign m23 = tz_q[PD-1];

	logic signed [15:0] one;
	assign one = 16'sd1;
	logic signed [31:0] scx, scy, scz;
	assign scx = sx_q[SD-1];
	assign scy = sy_q[SD-1];
	assign scz = sz_q[SD-1];

	// e02 = -sy*2^30: pair sy with -2^15, the pair path adds the other 2^15
	logic signed [15:0] k15;
	assign k15 = 16'sh8000;

	tmb_entry u_e00 (.clk, .en, .a(ry.cs), .b(rz.cs),
		.c(one), .d(one), .e(one), .neg1(1'b0), .neg2(1'b0), .use2(1'b0), .scale(scx), .m(m00));
	tmb_entry u_e01 (.clk, .en, .a(ry.cs), .b(rz.sn),
		.c(one), .d(one), .e(one), .neg1(1'b1), .neg2(1'b0), .use2(1'b0), .scale(scy), .m(m01));
	tmb_entry u_e02 (.clk, .en, .a(ry.sn), .b(k15),
		.c(one), .d(one), .e(one), .neg1(1'b0), .neg2(1'b0), .use2(1'b0), .scale(scz), .m(m02));
	tmb_entry u_e10 (.clk, .en, .a(rx.cs), .b(rz.sn),
		.c(rx.sn), .d(ry.sn), .e(rz.cs), .neg1(1'b0), .neg2(1'b1), .use2(1'b1), .scale(scx), .m(m10));
	tmb_entry u_e11 (.clk, .en, .a(rx.cs), .b(rz.cs),
		.c(rx.sn), .d(ry.sn), .e(rz.sn), .neg1(1'b0), .neg2(1'b0), .use2(1'b1), .scale(scy), .m(m11));
	tmb_entry u_e12 (.clk, .en, .a(rx.sn), .b(ry.cs),
		.c(one), .d(one), .e(one), .neg1(1'b1), .neg2(1'b0), .use2(1'b0), .scale(scz), .m(m12));
	tmb_entry u_e20 (.clk, .en, .a(rx.sn), .b(rz.sn),
		.c(rx.cs), .d(ry.sn), .e(rz.cs), .neg1(1'b0), .neg2(1'b0), .use2(1'b1), .scale(scx), .m(m20));
	tmb_entry u_e21 (.clk, .en, .a(rx.sn), .b(rz.cs),
		.c(rx.cs), .d(ry.sn), .e(rz.sn), .neg1(1'b0), .neg2(1'b1), .use2(1'b1), .scale(scy), .m(m21));
	tmb_entry u_e22 (.clk, .en, .a(rx.cs), .b(ry.cs),
		.c(one), .d(one), .e(one), .neg1(1'b0), .neg2(1'b0), .use2(1'b0), .scale(scz), .m(m22));
endmodule

// ===== sv/tmb_checker.sv =====
// Port-level checks for the model matrix builder, bound to the top level.
// Depends on trs_model_matrix_builder ports only.
module tmb_assert (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] m03,
	input logic signed [31:0] m00
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(m03) && $stable(m00))
		else $error("output beat changed under stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during stall");
endmodule

bind trs_model_matrix_builder tmb_assert u_tmb_assert (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .m03, .m00);

// ===== tb/tmb_checker.sv =====
// Watches both channels of the model matrix builder, predicts each matrix
// and compares it with what comes out. Depends on tmb_pkg.
module tmb_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] pos_x, pos_y, pos_z,
	input  logic signed [15:0] angle_x, angle_y, angle_z,
	input  logic signed [31:0] scale_x, scale_y, scale_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] m00, m01, m02, m03,
	input  logic signed [31:0] m10, m11, m12, m13,
	input  logic signed [31:0] m20, m21, m22, m23,
	output int                 fail_count,
	output int                 pending
);
	typedef logic [11:0][31:0] matrix_t;

	matrix_t matrix_q[$];
	string   entry_name[12] = '{"m00", "m01", "m02", "m03", "m10", "m11", "m12", "m13",
		"m20", "m21", "m22", "m23"};

	// quarter-wave polynomial, z in Q30, result Q1.15 capped at 32767
	function automatic longint quarter_wave(longint unsigned z);
		longint unsigned z2, t;
		z2 = (z * z) >> 30;
		t  = (z2 * 64'(tmb_pkg::POLY_C)) >> 30;
		t  = 64'(tmb_pkg::POLY_B) - t;
		t  = (z2 * t) >> 30;
		t  = 64'(tmb_pkg::POLY_A) - t;
		t  = (z * t) >> 30;
		t  = (t + 64'd16384) >> 15;
		if (t > 64'd32767)
			t = 64'd32767;
		return longint'(t);
	endfunction

	function automatic longint wave(logic [1:0] quad, longint unsigned z);
		longint s;
		s = quad[0] ? quarter_wave(64'(tmb_pkg::ONE_Q30) - z) : quarter_wave(z);
		return quad[1] ? -s : s;
	endfunction

	function automatic longint round_shift(longint v, int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic matrix_t build_matrix(logic [31:0] p[3], logic [15:0] a[3],
			logic [31:0] s[3]);
		longint sn[3], cs[3], e[3][3], q30, v;
		longint unsigned z;
		matrix_t m;
		for (int i = 0; i < 3; i++) begin
			z = longint'(a[i][13:0]) << 16;
			sn[i] = wave(a[i][15:14], z);
			cs[i] = wave(a[i][15:14] + 2'd1, z);
		end
		e[0][0] = cs[1] * cs[2] * 32768;
		e[0][1] = -(cs[1] * sn[2]) * 32768;
		e[0][2] = -sn[1] * (longint'(1) << 30);
		e[1][0] = cs[0] * sn[2] * 32768 - (sn[0] * sn[1]) * cs[2];
		e[1][1] = cs[0] * cs[2] * 32768 + (sn[0] * sn[1]) * sn[2];
		e[1][2] = -(sn[0] * cs[1]) * 32768;
		e[2][0] = sn[0] * sn[2] * 32768 + (cs[0] * sn[1]) * cs[2];
		e[2][1] = sn[0] * cs[2] * 32768 - (cs[0] * sn[1]) * sn[2];
		e[2][2] = cs[0] * cs[1] * 32768;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				q30 = round_shift(e[r][c], 15);
				v = round_shift(q30 * longint'($signed(s[c])), 30);
				if (v > 64'sd2147483647)
					v = 64'sd2147483647;
				else if (v < -64'sd2147483648)
					v = -64'sd2147483648;
				m[r * 4 + c] = v[31:0];
			end
			m[r * 4 + 3] = p[r];
		end
		return m;
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	always @(posedge clk) begin
		matrix_t got, want;
		if (arst_n && in_valid && in_ready)
			matrix_q.push_back(build_matrix('{pos_x, pos_y, pos_z},
				'{angle_x, angle_y, angle_z}, '{scale_x, scale_y, scale_z}));
		if (arst_n && out_valid && out_ready) begin
			got = {m23, m22, m21, m20, m13, m12, m11, m10, m03, m02, m01, m00};
			if (matrix_q.size() == 0) begin
				$error("output beat with no matrix expected");
				fail_count++;
			end else begin
				want = matrix_q.pop_front();
				for (int i = 0; i < 12; i++)
					if (got[i] !== want[i]) begin
						$error("%s: expected %0d, got %0d", entry_name[i],
							$signed(want[i]), $signed(got[i]));
						fail_count++;
					end
			end
		end
		pending = matrix_q.size();
	end
endmodule

// ===== tb/trs_model_matrix_builder_test.sv =====
// Stimulus and verdict for the model matrix builder; the checker does the
// prediction. Depends on tmb_pkg, trs_model_matrix_builder, tmb_checker.
module trs_model_matrix_builder_test;
	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [15:0] angle_x = 0, angle_y = 0, angle_z = 0;
	logic signed [31:0] scale_x = 0, scale_y = 0, scale_z = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [31:0] m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23;
	int                 fail_count, pending;
	int                 cycles = 0;
	int                 sent = 0;
	bit                 calm = 0;

	trs_model_matrix_builder dut (.*);
	tmb_checker watch (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 100000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);

	// hold the beat until accepted; maybe drop valid for a random stretch first
	task automatic send_object(logic [31:0] px, py, pz, logic [15:0] ax, ay, az,
			logic [31:0] sx, sy, sz);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 0;
			@(posedge clk);
		end
		pos_x <= px; pos_y <= py; pos_z <= pz;
		angle_x <= ax; angle_y <= ay; angle_z <= az;
		scale_x <= sx; scale_y <= sy; scale_z <= sz;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic [31:0] any_scale();
		if ($urandom_range(3) == 0)
			return $urandom;
		return $signed($urandom_range(32'h80000)) - 32'sh40000;
	endfunction

	initial begin
		logic [15:0] dir_angle[8] = '{16'sd0, 16'sd16384, 16'sh8000, -16'sd16384,
			16'sd32767, 16'sd8192, -16'sd1, 16'sd1};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity, then quadrant boundaries and nearby angles on each axis
		send_object(0, 0, 0, 16'd0, 16'd0, 16'd0, 32'h10000, 32'h10000, 32'h10000);
		for (int i = 0; i < 8; i++)
			send_object(32'h7fffffff, 32'h80000000, 32'hffffffff,
				dir_angle[i], dir_angle[(i + 3) % 8], dir_angle[(i + 5) % 8],
				32'h10000, 32'hfffe0000, 32'h00030000);
		// saturation in both directions at full scale
		for (int i = 0; i < 8; i++)
			send_object(32'h80000000, 32'h7fffffff, 0,
				dir_angle[i], dir_angle[7 - i], dir_angle[(i + 2) % 8],
				32'h7fffffff, 32'h80000000, i[0] ? 32'h7fffffff : 32'h80000000);
		send_object(1, -1, 0, 16'sd12345, -16'sd23456, 16'sd4096, 0, 1, -1);

		// drain completely before the random part
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		for (int n = 0; n < 1100; n++) begin
			calm = (n >= 400 && n < 600);
			send_object($urandom, $urandom, $urandom,
				16'($urandom), 16'($urandom), 16'($urandom),
				any_scale(), any_scale(), any_scale());
		end
		in_valid <= 0;
		calm = 0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d objects: quadrant edges, full-scale saturation and random",
			sent);
		$display("poses, with stalls on both sides and one full drain.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
